/* hw/rtl/fadd_pkg.sv */
// ----------------------------------------------------------------------------
// fadd_pkg
// Shared types and constants for the truncating single-precision adder.
// ----------------------------------------------------------------------------
package fadd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ExpW     = 8;
  localparam int unsigned MantW    = 24;
  localparam int unsigned QueueDepthDef = 2;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    logic             is_zero;  // result is a signed zero already
    logic             sign;     // result sign
    logic             sub;      // unlike signs: subtract
    logic [ExpW-1:0]  exp;      // larger exponent
    logic [MantW-1:0] mant_l;   // larger mantissa
    logic [MantW-1:0] mant_s;   // aligned smaller mantissa
  } fadd_item_t;

endpackage

/* hw/rtl/fadd_front.sv */
// ----------------------------------------------------------------------------
// fadd_front
// Unpack, order by magnitude and align the smaller mantissa; one item a cycle.
// ----------------------------------------------------------------------------
module fadd_front import fadd_pkg::*; (
  input  logic [WordW-1:0] operand_a_i,
  input  logic [WordW-1:0] operand_b_i,
  output fadd_item_t       item_o
);

  logic             sa, sb;
  logic [ExpW-1:0]  ea, eb, el, es, diff;
  logic [MantW-1:0] ma, mb, ml, ms;
  logic             a_big, sl;

  always_comb begin
    sa = operand_a_i[31];
    sb = operand_b_i[31];
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    ma = (ea != '0) ? {1'b1, operand_a_i[22:0]} : '0;
    mb = (eb != '0) ? {1'b1, operand_b_i[22:0]} : '0;
    // pick the larger operand; like signs compare exponents only
    if (sa == sb) a_big = (ea >= eb);
    else          a_big = ({ea, ma} > {eb, mb});
    el = a_big ? ea : eb;
    ml = a_big ? ma : mb;
    es = a_big ? eb : ea;
    ms = a_big ? mb : ma;
    sl = a_big ? sa : sb;
    diff = el - es;
    item_o.sign   = (sa == sb) ? sa : sl;
    item_o.sub    = (sa != sb);
    item_o.is_zero = (sa != sb) && ({ea, ma} == {eb, mb});
    if (item_o.is_zero) item_o.sign = 1'b0;
    item_o.exp    = el;
    item_o.mant_l = ml;
    item_o.mant_s = (diff >= 8'd24) ? '0 : (ms >> diff[4:0]);
  end

endmodule

/* hw/rtl/fadd_queue.sv */
// ----------------------------------------------------------------------------
// fadd_queue
// Short FIFO that decouples the front and back parts.
// ----------------------------------------------------------------------------
module fadd_queue import fadd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fadd_item_t data_i,
  input  logic       pop_i,
  output fadd_item_t data_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  fadd_item_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign data_o  = mem_q[rd_q];

  // advance pointers with wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // store item
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* hw/rtl/fadd_back.sv */
// ----------------------------------------------------------------------------
// fadd_back
// Add or subtract mantissas, normalize one bit a cycle, pack the result.
// ----------------------------------------------------------------------------
module fadd_back import fadd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  fadd_item_t       item_i,
  output logic             take_o,
  output logic             strobe_o,
  output logic [WordW-1:0] sum_bits_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_NORM = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic             sign_q, sign_d;
  logic [ExpW-1:0]  exp_q, exp_d;
  logic [MantW:0]   mant_q, mant_d;
  logic             zero_q, zero_d;
  logic [MantW:0]   sum;

  assign take_o = (state_q == ST_IDLE) && valid_i;

  always_comb begin
    state_d = state_q;
    sign_d  = sign_q;
    exp_d   = exp_q;
    mant_d  = mant_q;
    zero_d  = zero_q;
    sum = item_i.sub ? ({1'b0, item_i.mant_l} - {1'b0, item_i.mant_s})
                     : ({1'b0, item_i.mant_l} + {1'b0, item_i.mant_s});
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          sign_d = item_i.sign;
          exp_d  = item_i.exp;
          zero_d = item_i.is_zero || (sum == '0);
          if (sum[MantW]) begin
            // carry: shift right, raise exponent (255 saturates in pack)
            mant_d = sum >> 1;
            exp_d  = (item_i.exp == ExpMax) ? ExpMax : item_i.exp + 1'b1;
            state_d = ST_OUT;
            if (item_i.exp == ExpMax) zero_d = 1'b0;
          end else begin
            mant_d  = sum;
            state_d = (sum[MantW-1] || zero_d) ? ST_OUT : ST_NORM;
          end
        end
      end
      ST_NORM: begin
        // shift left one bit; flush on underflow
        if (exp_q <= 8'd1) begin
          zero_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          mant_d = mant_q << 1;
          exp_d  = exp_q - 1'b1;
          if (mant_q[MantW-2]) state_d = ST_OUT;
        end
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    exp_q  <= exp_d;
    mant_q <= mant_d;
    zero_q <= zero_d;
  end

  // pack result
  assign strobe_o = (state_q == ST_OUT);
  always_comb begin
    if (zero_q)              sum_bits_o = {sign_q, 31'b0};
    else if (exp_q == ExpMax) sum_bits_o = {sign_q, ExpMax, 23'b0};
    else                     sum_bits_o = {sign_q, exp_q, mant_q[22:0]};
  end

endmodule

/* hw/rtl/float32_adder_truncating_top.sv */
// Truncating single-precision adder.
// A started item is stored in the queue and taken by the back part when it is
// idle; the back part normalizes left one bit a cycle, at most 23 bits. It
// takes no new item until it is through with the last; the front part and a
// short queue keep accepting while it works, until the queue is full (busy).
// Reset (async, active low) empties the queue; the receiver cannot stall.
module float32_adder_truncating_top import fadd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [WordW-1:0] operand_a_i,
  input  logic [WordW-1:0] operand_b_i,
  output logic             sum_strobe_o,
  output logic [WordW-1:0] sum_bits_o
);

  fadd_item_t front_item, queue_item;
  logic       q_empty, q_full, take;

  assign busy = q_full;

  fadd_front u_front (
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .item_o     (front_item)
  );

  fadd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start && !q_full),
    .data_i (front_item),
    .pop_i  (take),
    .data_o (queue_item),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  fadd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (!q_empty),
    .item_i    (queue_item),
    .take_o    (take),
    .strobe_o  (sum_strobe_o),
    .sum_bits_o(sum_bits_o)
  );

endmodule
